@@ rtl/core/nearest_frame_slot_finder_assert.svh @@
`ifndef NEAREST_FRAME_SLOT_FINDER_ASSERT_SVH
`define NEAREST_FRAME_SLOT_FINDER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define NFSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define NFSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/nfsf_pkg.sv @@
`default_nettype none

package nfsf_pkg;

  // default table geometry
  localparam int NUM_SLOTS_DEF = 16;
  localparam int CAM_COUNT_DEF = 4;

  // payload widths
  localparam int CAM_W       = 2;
  localparam int SLOT_W      = 5;
  localparam int FRAME_W     = 32;
  localparam int DIST_W      = FRAME_W + 1;
  localparam int CFG_CAMS_W  = 3;
  localparam int CFG_SLOTS_W = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;

  // request kinds
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAMS_IN_USE  = 2'd0,
    CFG_SLOTS_IN_USE = 2'd1
  } cfg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic clr_en;
    logic wr_en;
    logic qry_start;
    logic pref_chk;
    logic scan;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic query_bad;
    logic pref_hit;
    logic scan_hit;
    logic scan_last;
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/nfsf_req_if.sv @@
`default_nettype none

interface nfsf_req_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic [nfsf_pkg::CAM_W-1:0]          camera;
  logic signed [nfsf_pkg::SLOT_W-1:0]  slot_sel;
  logic signed [nfsf_pkg::FRAME_W-1:0] frame_value;
  logic                                entry_busy;

  modport source (
    output valid, mode, camera, slot_sel, frame_value, entry_busy,
    input  ready
  );
  modport sink (
    input  valid, mode, camera, slot_sel, frame_value, entry_busy,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/nfsf_rsp_if.sv @@
`default_nettype none

interface nfsf_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [nfsf_pkg::SLOT_W-1:0] found_slot;

  modport source (output valid, found_slot, input ready);
  modport sink (input valid, found_slot, output ready);
endinterface

`default_nettype wire

@@ rtl/core/nfsf_cfg_if.sv @@
`default_nettype none

interface nfsf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [nfsf_pkg::CFG_IDX_W-1:0]      index;
  logic [nfsf_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/nfsf_ctrl.sv @@
`default_nettype none

`include "nearest_frame_slot_finder_assert.svh"

module nfsf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_mode,
  output logic                   in_ready,
  input  wire nfsf_pkg::dp_sts_t st,
  output nfsf_pkg::dp_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_CLEAR   = 5'b00001,
    S_IDLE    = 5'b00010,
    S_PREF    = 5'b00100,
    S_SCAN    = 5'b01000,
    S_RESOLVE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == nfsf_pkg::MODE_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.qry_start = 1'b1;
            state_next    = st.query_bad ? S_RESOLVE : S_PREF;
          end
        end
      end
      S_PREF: begin
        cmd.pref_chk = 1'b1;
        state_next   = st.pref_hit ? S_RESOLVE : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_hit || st.scan_last) begin
          state_next = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // checks
  `NFSF_ASSERT_NXT(a_clear_once, state != S_CLEAR, state != S_CLEAR,
                   "clearing pass entered again after it finished")
  `NFSF_ASSERT_NXT(a_query_path,
                   state == S_IDLE && in_valid && in_mode == nfsf_pkg::MODE_QUERY,
                   state == S_PREF || state == S_RESOLVE,
                   "accepted query did not start its search")

endmodule

`default_nettype wire

@@ rtl/core/nfsf_dp.sv @@
`default_nettype none

`include "nearest_frame_slot_finder_assert.svh"

module nfsf_dp #(
  parameter int NUM_SLOTS = nfsf_pkg::NUM_SLOTS_DEF,
  parameter int CAM_COUNT = nfsf_pkg::CAM_COUNT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire nfsf_pkg::dp_cmd_t                   cmd,
  output nfsf_pkg::dp_sts_t                        st,
  input  wire logic [nfsf_pkg::CAM_W-1:0]          in_camera,
  input  wire logic signed [nfsf_pkg::SLOT_W-1:0]  in_slot,
  input  wire logic signed [nfsf_pkg::FRAME_W-1:0] in_frame,
  input  wire logic                                in_busy,
  input  wire logic                                cfg_valid,
  input  wire logic [nfsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [nfsf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic signed [nfsf_pkg::SLOT_W-1:0]       out_slot
);

  localparam int DEPTH  = CAM_COUNT * NUM_SLOTS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW     = nfsf_pkg::SLOT_W;
  localparam int FW     = nfsf_pkg::FRAME_W;
  localparam int DW     = nfsf_pkg::DIST_W;
  localparam int CNT_W  = nfsf_pkg::CFG_SLOTS_W;

  // configuration registers
  logic [nfsf_pkg::CFG_CAMS_W-1:0]  cams_in_use;
  logic [nfsf_pkg::CFG_SLOTS_W-1:0] slots_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      cams_in_use  <= '0;
      slots_in_use <= '0;
    end else if (cfg_valid) begin
      case (nfsf_pkg::cfg_idx_t'(cfg_index))
        nfsf_pkg::CFG_CAMS_IN_USE:  cams_in_use  <= cfg_data[nfsf_pkg::CFG_CAMS_W-1:0];
        nfsf_pkg::CFG_SLOTS_IN_USE: slots_in_use <= cfg_data[nfsf_pkg::CFG_SLOTS_W-1:0];
        default: ;
      endcase
    end
  end

  // request decode
  logic          cam_exists;
  logic          slot_ok;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] in_base;

  assign cam_exists = int'(in_camera) < CAM_COUNT;
  assign slot_ok    = !in_slot[SW-1]
                   && ({1'b0, in_slot[SW-2:0]} < slots_in_use)
                   && (int'(in_slot[SW-2:0]) < NUM_SLOTS);
  assign in_base    = AW'(int'(in_camera) * NUM_SLOTS);
  assign in_addr    = AW'(int'(in_camera) * NUM_SLOTS + int'(in_slot[SW-2:0]));

  assign st.query_bad = !cam_exists
                     || !({1'b0, in_camera} < cams_in_use)
                     || (slots_in_use == '0)
                     || (int'(slots_in_use) > NUM_SLOTS);

  // query context
  logic                 bad_q;
  logic [AW-1:0]        base_q;
  logic signed [FW-1:0] tgt_q;
  logic signed [SW-1:0] pref_q;
  logic                 pref_ok_q;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     cnt_inc;

  assign cnt_inc      = cnt + 1'b1;
  assign st.scan_last = cnt_inc == slots_in_use;

  // clearing pass counter
  logic [AW-1:0] clr_addr;

  assign st.clr_last = clr_addr == AW'(DEPTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // slot tables with one registered read port
  logic          occ_mem [DEPTH];
  logic [FW-1:0] frm_mem [DEPTH];
  logic [AW-1:0] rd_addr;
  logic          occ_q;
  logic signed [FW-1:0] frm_q;
  logic          wr_hit;

  assign wr_hit = cmd.wr_en && cam_exists && slot_ok;

  always_comb begin
    if (cmd.pref_chk) begin
      rd_addr = base_q;
    end else if (cmd.scan) begin
      rd_addr = base_q + AW'(cnt_inc);
    end else begin
      rd_addr = in_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      occ_mem[clr_addr] <= 1'b0;
    end else if (wr_hit) begin
      occ_mem[in_addr] <= in_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      frm_mem[in_addr] <= in_frame;
    end
  end

  always_ff @(posedge clk) begin
    occ_q <= occ_mem[rd_addr];
    frm_q <= frm_mem[rd_addr];
  end

  // evaluation of the slot just read
  logic          d_valid;
  logic [DW-1:0] d_pos;
  logic [DW-1:0] d_neg;
  logic [DW-1:0] gap;

  assign d_valid = occ_q && !frm_q[FW-1];
  assign d_pos   = {frm_q[FW-1], frm_q} - {tgt_q[FW-1], tgt_q};
  assign d_neg   = {tgt_q[FW-1], tgt_q} - {frm_q[FW-1], frm_q};
  assign gap     = d_pos[DW-1] ? d_neg : d_pos;

  assign st.pref_hit = pref_ok_q && d_valid && (tgt_q[FW-1] || frm_q == tgt_q);
  assign st.scan_hit = d_valid && (frm_q == tgt_q);

  // best candidates so far
  logic                 hit;
  logic [SW-1:0]        hit_slot;
  logic                 low_ok;
  logic signed [FW-1:0] low_frame;
  logic [SW-1:0]        low_slot;
  logic                 abs_ok;
  logic [DW-1:0]        abs_dist;
  logic [SW-1:0]        abs_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit    <= 1'b0;
      low_ok <= 1'b0;
      abs_ok <= 1'b0;
      bad_q  <= 1'b0;
    end else if (cmd.qry_start) begin
      hit    <= 1'b0;
      low_ok <= 1'b0;
      abs_ok <= 1'b0;
      bad_q  <= st.query_bad;
    end else if (cmd.pref_chk) begin
      if (st.pref_hit) begin
        hit <= 1'b1;
      end
    end else if (cmd.scan && d_valid) begin
      if (st.scan_hit) begin
        hit <= 1'b1;
      end
      if (frm_q <= tgt_q) begin
        low_ok <= 1'b1;
      end
      abs_ok <= 1'b1;
    end
  end

  // payload of the query context and candidates
  always_ff @(posedge clk) begin
    if (cmd.qry_start) begin
      base_q    <= in_base;
      tgt_q     <= in_frame;
      pref_q    <= in_slot;
      pref_ok_q <= slot_ok;
    end
    if (cmd.pref_chk) begin
      cnt <= '0;
      if (st.pref_hit) begin
        hit_slot <= pref_q;
      end
    end
    if (cmd.scan) begin
      cnt <= cnt_inc;
      if (d_valid) begin
        if (st.scan_hit) begin
          hit_slot <= SW'(cnt);
        end
        if ((frm_q <= tgt_q) && (!low_ok || frm_q > low_frame)) begin
          low_frame <= frm_q;
          low_slot  <= SW'(cnt);
        end
        if (!abs_ok || gap < abs_dist) begin
          abs_dist <= gap;
          abs_slot <= SW'(cnt);
        end
      end
    end
  end

  // result register
  assign st.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (bad_q) begin
        out_slot <= '1;
      end else if (hit) begin
        out_slot <= hit_slot;
      end else if (low_ok) begin
        out_slot <= low_slot;
      end else if (abs_ok) begin
        out_slot <= abs_slot;
      end else begin
        out_slot <= '1;
      end
    end
  end

  // checks
  `NFSF_ASSERT_IMP(a_no_overwrite, cmd.load_out, !(out_valid && !out_ready),
                   "pending result overwritten")
  `NFSF_ASSERT_IMP(a_scan_bound, cmd.scan, cnt < slots_in_use,
                   "scan ran past the slots in use")

endmodule

`default_nettype wire

@@ rtl/core/nearest_frame_slot_finder.sv @@
// Frame slot lookup per camera. A write request (mode 0) updates one slot's occupied flag and
// frame number; a query request (mode 1) picks the preferred slot if it holds the target frame
// or the target is negative, else the first exact match, else the greatest frame at or below
// the target, else the nearest frame, else -1. After reset all CAM_COUNT*NUM_SLOTS occupied
// flags (64 by default) are cleared one entry a cycle while req.ready stays low; cfg writes
// are taken at any time. A query skips the search when camera or slot count is out of range,
// stops after the preferred-slot check when that slot wins, and else scans the slots in use up
// to the first exact match, one entry per cycle through the single table read port. One result
// register holds the answer, so a new request is taken while it waits on rsp.ready.
`default_nettype none

module nearest_frame_slot_finder #(
  parameter int NUM_SLOTS = nfsf_pkg::NUM_SLOTS_DEF,
  parameter int CAM_COUNT = nfsf_pkg::CAM_COUNT_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  nfsf_req_if.sink   req,
  nfsf_rsp_if.source rsp,
  nfsf_cfg_if.sink   cfg
);

  nfsf_pkg::dp_cmd_t cmd;
  nfsf_pkg::dp_sts_t st;

  // register writes are always taken
  assign cfg.ready = 1'b1;

  // sequencer
  nfsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_mode  (req.mode),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // tables, search and result register
  nfsf_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .CAM_COUNT (CAM_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_camera (req.camera),
    .in_slot   (req.slot_sel),
    .in_frame  (req.frame_value),
    .in_busy   (req.entry_busy),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .out_slot  (rsp.found_slot)
  );

endmodule

`default_nettype wire

@@ sim/nearest_frame_slot_finder_tb.sv @@
`timescale 1ns / 1ps

module nearest_frame_slot_finder_tb;
  import nfsf_pkg::*;

  localparam int NUM_SLOTS = NUM_SLOTS_DEF;
  localparam int CAM_COUNT = CAM_COUNT_DEF;
  localparam logic signed [SLOT_W-1:0] NO_SLOT = -5'sd1;
  // headroom beyond the longest query, a full scan of the slots in use
  localparam int SETTLE_CYCLES = 32;
  localparam int N_PHASES = 9;
  localparam int DIR_ROWS = 26;

  logic clk;
  logic rst;
  bit calm;
  int mismatch_count;

  nfsf_req_if req_bus ();
  nfsf_rsp_if rsp_bus ();
  nfsf_cfg_if cfg_bus ();

  nearest_frame_slot_finder i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus),
    .cfg(cfg_bus)
  );

  // shadow of the slot tables and the registers
  bit occ [CAM_COUNT*NUM_SLOTS];
  logic signed [FRAME_W-1:0] frm [CAM_COUNT*NUM_SLOTS];
  int cams_cfg;
  int slots_cfg;

  logic signed [SLOT_W-1:0] slot_answers_q [$];

  typedef struct {
    logic is_cfg;
    cfg_idx_t idx;
    int data;
    logic mode;
    logic [CAM_W-1:0] cam;
    logic signed [SLOT_W-1:0] slot;
    logic signed [FRAME_W-1:0] frame;
    logic busy;
    logic has_want;
    logic signed [SLOT_W-1:0] want;
  } dir_row_t;

  // directed stimulus; want is typed in only for the obvious answers
  dir_row_t dir_tab [DIR_ROWS] = '{
    // bad camera right after reset
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_QUERY, 2'd0, -5'sd1, 32'sd0, 1'b0, 1'b1, NO_SLOT},
    '{1'b1, CFG_CAMS_IN_USE, 4, MODE_WRITE, 2'd0, 5'sd0, 32'sd0, 1'b0, 1'b0, NO_SLOT},
    // zero slot count
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_QUERY, 2'd0, -5'sd1, 32'sd0, 1'b0, 1'b1, NO_SLOT},
    '{1'b1, CFG_SLOTS_IN_USE, 16, MODE_WRITE, 2'd0, 5'sd0, 32'sd0, 1'b0, 1'b0, NO_SLOT},
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_WRITE, 2'd0, 5'sd0, 32'sd100, 1'b1, 1'b0, NO_SLOT},
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_WRITE, 2'd0, 5'sd1, 32'sd50, 1'b1, 1'b0, NO_SLOT},
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_WRITE, 2'd0, 5'sd2, 32'sd200, 1'b1, 1'b0, NO_SLOT},
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_WRITE, 2'd0, 5'sd15, 32'sh7fffffff, 1'b1, 1'b0, NO_SLOT},
    // exact match by scan
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_QUERY, 2'd0, -5'sd1, 32'sd50, 1'b0, 1'b0, NO_SLOT},
    // preferred slot matches
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_QUERY, 2'd0, 5'sd0, 32'sd100, 1'b0, 1'b1, 5'sd0},
    // negative target takes the preferred slot
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_QUERY, 2'd0, 5'sd2, -32'sd5, 1'b0, 1'b1, 5'sd2},
    // greatest frame at or below
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_QUERY, 2'd0, -5'sd1, 32'sd150, 1'b0, 1'b0, NO_SLOT},
    // nearest frame, preferred misses
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_QUERY, 2'd0, 5'sd1, 32'sd10, 1'b0, 1'b0, NO_SLOT},
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_QUERY, 2'd0, 5'sd15, 32'sh7fffffff, 1'b0, 1'b1, 5'sd15},
    // most negative target, widest distance
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_QUERY, 2'd0, -5'sd1, 32'sh80000000, 1'b0, 1'b0, NO_SLOT},
    // occupied but negative frames are not valid
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_WRITE, 2'd1, 5'sd3, -32'sd7, 1'b1, 1'b0, NO_SLOT},
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_WRITE, 2'd1, 5'sd4, 32'sh80000000, 1'b1, 1'b0, NO_SLOT},
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_QUERY, 2'd1, 5'sd3, 32'sd0, 1'b0, 1'b0, NO_SLOT},
    // negative slot write is dropped
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_WRITE, 2'd0, 5'sh10, 32'sd0, 1'b1, 1'b0, NO_SLOT},
    // distance tie, earliest slot wins
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_WRITE, 2'd3, 5'sd0, 32'sd30, 1'b1, 1'b0, NO_SLOT},
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_WRITE, 2'd3, 5'sd1, 32'sd30, 1'b1, 1'b0, NO_SLOT},
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_QUERY, 2'd3, -5'sd1, 32'sd20, 1'b0, 1'b0, NO_SLOT},
    // camera beyond cams_in_use
    '{1'b1, CFG_CAMS_IN_USE, 2, MODE_WRITE, 2'd0, 5'sd0, 32'sd0, 1'b0, 1'b0, NO_SLOT},
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_QUERY, 2'd3, -5'sd1, 32'sd30, 1'b0, 1'b1, NO_SLOT},
    // slot count beyond the table
    '{1'b1, CFG_SLOTS_IN_USE, 31, MODE_WRITE, 2'd0, 5'sd0, 32'sd0, 1'b0, 1'b0, NO_SLOT},
    '{1'b0, CFG_CAMS_IN_USE, 0, MODE_QUERY, 2'd0, 5'sd0, 32'sd100, 1'b0, 1'b1, NO_SLOT}
  };

  // register settings per random phase, the last one runs without idling
  int ph_cams [N_PHASES] = '{4, 1, 4, 7, 4, 0, 3, 2, 4};
  int ph_slots [N_PHASES] = '{16, 1, 8, 16, 31, 0, 4, 12, 16};

  function automatic bit entry_ok(int base, int s);
    if (s < 0 || s >= slots_cfg || s >= NUM_SLOTS) return 1'b0;
    return occ[base+s] && frm[base+s] >= 0;
  endfunction

  // slot the block should pick for a query
  function automatic logic signed [SLOT_W-1:0] pick_slot(int cam,
      logic signed [FRAME_W-1:0] target, int pref);
    int base;
    int lower_slot;
    int near_slot;
    logic signed [FRAME_W-1:0] lower_frame;
    logic signed [FRAME_W-1:0] f;
    logic signed [DIST_W-1:0] diff;
    logic [DIST_W-1:0] gap;
    logic [DIST_W-1:0] near_dist;
    lower_slot = -1;
    near_slot = -1;
    lower_frame = '0;
    near_dist = '0;
    if (cam >= cams_cfg || cam >= CAM_COUNT) return NO_SLOT;
    if (slots_cfg == 0 || slots_cfg > NUM_SLOTS) return NO_SLOT;
    base = cam * NUM_SLOTS;
    if (entry_ok(base, pref) && (target < 0 || frm[base+pref] == target)) return 5'(pref);
    for (int i = 0; i < slots_cfg; i++) begin
      if (entry_ok(base, i)) begin
        f = frm[base+i];
        if (f == target) return 5'(i);
        if (f <= target && (lower_slot < 0 || f > lower_frame)) begin
          lower_frame = f;
          lower_slot = i;
        end
        diff = 33'(f) - 33'(target);
        gap = (diff < 0) ? -diff : diff;
        if (near_slot < 0 || gap < near_dist) begin
          near_dist = gap;
          near_slot = i;
        end
      end
    end
    if (lower_slot >= 0) return 5'(lower_slot);
    return 5'(near_slot);
  endfunction

  // present one request, hold it until taken, then update the shadow
  task automatic send_req(logic mode, logic [CAM_W-1:0] cam, logic signed [SLOT_W-1:0] slot,
      logic signed [FRAME_W-1:0] frame, logic busy, logic has_want,
      logic signed [SLOT_W-1:0] want);
    int k;
    req_bus.valid <= 1'b1;
    req_bus.mode <= mode;
    req_bus.camera <= cam;
    req_bus.slot_sel <= slot;
    req_bus.frame_value <= frame;
    req_bus.entry_busy <= busy;
    do @(posedge clk); while (!req_bus.ready);
    if (mode == MODE_WRITE) begin
      if (cam < CAM_COUNT && slot >= 0 && slot < slots_cfg && slot < NUM_SLOTS) begin
        k = cam * NUM_SLOTS + slot;
        occ[k] = busy;
        frm[k] = frame;
      end
    end else begin
      slot_answers_q.push_back(has_want ? want : pick_slot(cam, frame, slot));
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, int value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == CFG_CAMS_IN_USE) cams_cfg = value & 7;
    else slots_cfg = value & 31;
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid, then wait for every pending answer
  task automatic drain();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (slot_answers_q.size() != 0);
  endtask

  // idle point for register writes: nothing pending, last write settled
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // random request, biased toward in-range slots and a small pool of frames
  task automatic random_req();
    logic m;
    logic signed [SLOT_W-1:0] s;
    logic signed [FRAME_W-1:0] f;
    int r;
    int top;
    m = ($urandom_range(0, 99) < 45) ? MODE_WRITE : MODE_QUERY;
    top = (slots_cfg >= 1 && slots_cfg <= NUM_SLOTS) ? slots_cfg - 1 : NUM_SLOTS - 1;
    r = $urandom_range(0, 9);
    if (r < 7) s = 5'($urandom_range(0, top));
    else if (r == 7) s = NO_SLOT;
    else s = 5'($urandom());
    r = $urandom_range(0, 9);
    if (r < 6) f = $urandom_range(0, 40);
    else if (r == 6) f = -$signed(32'($urandom_range(1, 40)));
    else if (r < 9) f = $urandom();
    else f = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    send_req(m, 2'($urandom_range(0, 3)), s, f, $urandom_range(0, 7) != 0, 1'b0, NO_SLOT);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("nearest_frame_slot_finder test failed");
    $finish;
  end

  // response side backpressure in random bursts
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      if (calm) begin
        rsp_bus.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        rsp_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        rsp_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // compare each taken response with the oldest predicted slot
  always @(posedge clk) begin : check_rsp
    logic signed [SLOT_W-1:0] want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (slot_answers_q.size() == 0) begin
        $display("%0t: unexpected response, found_slot %0d", $time, rsp_bus.found_slot);
        mismatch_count++;
      end else begin
        want = slot_answers_q.pop_front();
        if (rsp_bus.found_slot !== want) begin
          $display("%0t: found_slot mismatch, expected %0d, actual %0d",
                   $time, want, rsp_bus.found_slot);
          mismatch_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    int n;
    rst = 1'b1;
    calm = 1'b0;
    mismatch_count = 0;
    cams_cfg = 0;
    slots_cfg = 0;
    for (int i = 0; i < CAM_COUNT*NUM_SLOTS; i++) begin
      occ[i] = 1'b0;
      frm[i] = '0;
    end
    req_bus.valid = 1'b0;
    req_bus.mode = MODE_WRITE;
    req_bus.camera = '0;
    req_bus.slot_sel = '0;
    req_bus.frame_value = '0;
    req_bus.entry_busy = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_CAMS_IN_USE;
    cfg_bus.data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        settle();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        maybe_idle();
        send_req(dir_tab[i].mode, dir_tab[i].cam, dir_tab[i].slot, dir_tab[i].frame,
                 dir_tab[i].busy, dir_tab[i].has_want, dir_tab[i].want);
      end
    end

    // random phases, fewer requests where every query fails
    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      write_reg(CFG_CAMS_IN_USE, ph_cams[p]);
      write_reg(CFG_SLOTS_IN_USE, ph_slots[p]);
      calm = (p == N_PHASES - 1);
      n = (ph_cams[p] == 0 || ph_slots[p] == 0 || ph_slots[p] > NUM_SLOTS) ? 40 : 100;
      for (int k = 0; k < n; k++) begin
        // sender holds off once until the block has drained
        if (p == 0 && k == 50) drain();
        maybe_idle();
        random_req();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("nearest_frame_slot_finder test passed");
    end else begin
      $display("nearest_frame_slot_finder test failed");
    end
    $finish;
  end

endmodule
